// ----- src/swfd_pkg.sv -----
// Package for the scale weight frame decoder.
// Frame layout constants, status codes and config register indexes.
// No dependencies.
package swfd_pkg;

  localparam int unsigned FRAME_LEN = 20;
  localparam int unsigned CNT_W     = $clog2(FRAME_LEN + 1);
  localparam int unsigned IDX_W     = $clog2(FRAME_LEN);

  localparam logic [7:0] SIGN_MINUS  = 8'h2D;
  localparam logic [7:0] UNIT_OUNCES = 8'h02;
  localparam logic [7:0] SMOOTH_ON   = 8'h01;

  localparam logic [7:0] PRODUCT_ID_RST  = 8'd3;
  localparam logic [7:0] WEIGHT_TYPE_RST = 8'd11;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_TRUNC   = 3'd1,
    ST_BADPROD = 3'd2,
    ST_CKSUM   = 3'd3,
    ST_NOTWT   = 3'd4
  } status_e;

  typedef enum logic {
    CFG_PRODUCT_ID  = 1'b0,
    CFG_WEIGHT_TYPE = 1'b1
  } cfg_idx_e;

endpackage

// ----- src/swfd_if.sv -----
// Handshake channels of the scale weight frame decoder.
// Input word channel and result channel; depends on swfd_pkg.
interface swfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, output data_byte, output frame_end, input ready);
  modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

interface swfd_out_if;
  logic                   valid;
  logic                   ready;
  swfd_pkg::status_e      status;
  logic [23:0]            elapsed_ms;
  logic                   shows_ounces;
  logic signed [24:0]     weight_cg;
  logic signed [16:0]     flow_cg_per_s;
  logic [7:0]             battery_pct;
  logic [15:0]            standby_tenth_min;
  logic [7:0]             buzzer;
  logic                   smoothing_on;

  modport source (output valid, output status, output elapsed_ms, output shows_ounces,
                  output weight_cg, output flow_cg_per_s, output battery_pct,
                  output standby_tenth_min, output buzzer, output smoothing_on,
                  input ready);
  modport sink   (input valid, input status, input elapsed_ms, input shows_ounces,
                  input weight_cg, input flow_cg_per_s, input battery_pct,
                  input standby_tenth_min, input buzzer, input smoothing_on,
                  output ready);
endinterface

// ----- src/scale_weight_frame_decoder.sv -----
// Scale weight frame decoder: byte-wise notification parser with a registered result.
// Depends on swfd_pkg and the channel interfaces in swfd_if.sv.
//
// Takes one notification word (byte) per cycle and returns a single result on the
// word flagged frame_end. Sustained rate is one word per clock; a word is taken
// whenever the result register is empty or being drained in the same cycle, so
// the only stall comes from a result the sink has not yet taken. The result for
// a final word appears in the cycle after it is accepted. Frame bytes are held in a
// FRAME_LEN-entry register file; status checks run in the order truncated, bad
// product, checksum mismatch, not a weight frame. Decoded fields read zero
// unless the status is ok. product_id and weight_frame_type are written through
// the config port; the user must do so only while the block is idle (unchecked).
module scale_weight_frame_decoder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  swfd_pkg::cfg_idx_e   cfg_idx_i,
  input  logic [7:0]           cfg_data_i,
  swfd_in_if.sink              in_i,
  swfd_out_if.source           out_o
);
  import swfd_pkg::*;

  logic [7:0]       product_id_q;
  logic [7:0]       weight_type_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [7:0]       xor_q, xor_d;
  logic [7:0]       store_q [FRAME_LEN];
  logic [7:0]       frame_w [FRAME_LEN];

  logic             accept;
  logic             store_en;
  logic             out_valid_q;

  status_e          status_d;
  logic [23:0]      elapsed_d;
  logic             ounces_d;
  logic [24:0]      weight_mag;
  logic signed [24:0] weight_d;
  logic [16:0]      flow_mag;
  logic signed [16:0] flow_d;
  logic [15:0]      standby_d;
  logic             smooth_d;
  logic             ok;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign accept      = in_i.valid && in_i.ready;
  assign store_en    = count_q < CNT_W'(FRAME_LEN);
  assign out_o.valid = out_valid_q;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      product_id_q  <= PRODUCT_ID_RST;
      weight_type_q <= WEIGHT_TYPE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PRODUCT_ID:  product_id_q  <= cfg_data_i;
        CFG_WEIGHT_TYPE: weight_type_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Frame view including the word arriving this cycle
  always_comb begin
    for (int k = 0; k < FRAME_LEN; k++) begin
      frame_w[k] = (store_en && count_q[IDX_W-1:0] == IDX_W'(k)) ? in_i.data_byte
                                                                 : store_q[k];
    end
  end

  always_comb begin
    count_d = store_en ? count_q + CNT_W'(1) : count_q;
    xor_d   = (count_q < CNT_W'(FRAME_LEN - 1)) ? (xor_q ^ in_i.data_byte) : xor_q;
  end

  always_ff @(posedge clk_i) begin
    if (accept && store_en) begin
      store_q[count_q[IDX_W-1:0]] <= in_i.data_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      xor_q   <= '0;
    end else if (accept) begin
      if (in_i.frame_end) begin
        count_q <= '0;
        xor_q   <= '0;
      end else begin
        count_q <= count_d;
        xor_q   <= xor_d;
      end
    end
  end

  // Result decode
  always_comb begin
    if (count_d < CNT_W'(FRAME_LEN)) begin
      status_d = ST_TRUNC;
    end else if (frame_w[0] != product_id_q) begin
      status_d = ST_BADPROD;
    end else if (xor_d != frame_w[FRAME_LEN-1]) begin
      status_d = ST_CKSUM;
    end else if (frame_w[1] != weight_type_q) begin
      status_d = ST_NOTWT;
    end else begin
      status_d = ST_OK;
    end
    ok = (status_d == ST_OK);

    weight_mag = {1'b0, frame_w[7], frame_w[8], frame_w[9]};
    flow_mag   = {1'b0, frame_w[11], frame_w[12]};

    elapsed_d = ok ? {frame_w[2], frame_w[3], frame_w[4]} : '0;
    ounces_d  = ok && (frame_w[5] == UNIT_OUNCES);
    weight_d  = !ok ? '0 : (frame_w[6] == SIGN_MINUS) ? -$signed(weight_mag)
                                                      : $signed(weight_mag);
    flow_d    = !ok ? '0 : (frame_w[10] == SIGN_MINUS) ? -$signed(flow_mag)
                                                       : $signed(flow_mag);
    standby_d = ok ? {frame_w[14], frame_w[15]} : '0;
    smooth_d  = ok && (frame_w[17] == SMOOTH_ON);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && in_i.frame_end) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk_i) begin
    if (accept && in_i.frame_end) begin
      out_o.status            <= status_d;
      out_o.elapsed_ms        <= elapsed_d;
      out_o.shows_ounces      <= ounces_d;
      out_o.weight_cg         <= weight_d;
      out_o.flow_cg_per_s     <= flow_d;
      out_o.battery_pct       <= ok ? frame_w[13] : '0;
      out_o.standby_tenth_min <= standby_d;
      out_o.buzzer            <= ok ? frame_w[16] : '0;
      out_o.smoothing_on      <= smooth_d;
    end
  end

endmodule
